// ===== sv/lwma_difficulty_retarget_top_defines.svh =====
// assertion helpers for the lwma retarget block
`ifndef LWMA_DIFFICULTY_RETARGET_TOP_DEFINES_SVH
`define LWMA_DIFFICULTY_RETARGET_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, quiet during reset
`define LWMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lwma assertion failed");

// next-cycle implication, clocked on clk_i, quiet during reset
`define LWMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lwma assertion failed");

`endif

// ===== sv/lwma_pkg.sv =====
// ----------------------------------------------------------------------------
// lwma_pkg
// shared constants, types and compact-target decode for the retarget block
// ----------------------------------------------------------------------------
package lwma_pkg;

  localparam int unsigned WINDOW  = 90;
  localparam int unsigned RING    = WINDOW + 1;
  localparam int unsigned IDX_W   = $clog2(RING);
  localparam int unsigned SEEN_W  = $clog2(RING + 1);
  localparam int unsigned J_W     = $clog2(WINDOW + 1);
  localparam int unsigned T_W     = 16;
  localparam int unsigned CAP_W   = $clog2(6 * 65535 + 1);
  localparam longint unsigned TACC_MAX = longint'(6 * 65535) * WINDOW * (WINDOW + 1) / 2;
  localparam int unsigned TACC_W  = $clog2(TACC_MAX + 1);
  localparam int unsigned DIVK    = WINDOW * WINDOW * (WINDOW + 1) / 2;
  localparam int unsigned DIVK_W  = $clog2(DIVK + 1);
  localparam int unsigned DVSR_W  = $clog2(longint'(DIVK) * 65535 + 1);
  localparam int unsigned PREV_W  = 33;
  localparam int unsigned NUM_W   = 256;
  localparam int unsigned NBYTES  = NUM_W / 8;
  localparam int unsigned SIZE_W  = $clog2(NBYTES + 1);
  localparam int unsigned MCNT_W  = $clog2(TACC_W);
  localparam int unsigned DCNT_W  = $clog2(NUM_W);

  localparam logic [T_W-1:0] SPACING_RST = 16'd600;
  localparam logic [31:0]    LIMIT_RST   = 32'h1d00ffff;

  typedef enum logic {
    REG_SPACING = 1'b0,
    REG_LIMIT   = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_ENTRY,
    ST_DIV,
    ST_ACC,
    ST_MUL,
    ST_CLAMP,
    ST_NORM,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [NUM_W-1:0] decode_compact(input logic [31:0] c);
    logic [7:0]       sz;
    logic [NUM_W-1:0] m;
    logic [10:0]      sh;
    logic [NUM_W-1:0] r;
    sz = c[31:24];
    m  = {{(NUM_W-23){1'b0}}, c[22:0]};
    if (sz <= 8'd3) begin
      sh = {3'b000, 8'd3 - sz} << 3;
      r  = m >> sh;
    end else begin
      sh = {3'b000, sz - 8'd3} << 3;
      r  = m << sh;
    end
    return r;
  endfunction

endpackage

// ===== sv/lwma_div.sv =====
// ----------------------------------------------------------------------------
// lwma_div
// restoring divider, 256-bit dividend by the window divisor, one bit a cycle
// ----------------------------------------------------------------------------
module lwma_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [lwma_pkg::NUM_W-1:0]          dividend_i,
  input  logic [lwma_pkg::DVSR_W-1:0]         divisor_i,
  output logic [lwma_pkg::NUM_W-1:0]          quotient_o,
  output lwma_pkg::div_stat_t                 stat_o
);

  logic [lwma_pkg::NUM_W-1:0]  quo_q;
  logic [lwma_pkg::DVSR_W-1:0] rem_q;
  logic [lwma_pkg::DCNT_W-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [lwma_pkg::DVSR_W:0]   r2;
  logic                        ge;

  assign r2 = {rem_q, quo_q[lwma_pkg::NUM_W-1]};
  assign ge = r2 >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {lwma_pkg::DCNT_W{1'b1}}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[lwma_pkg::NUM_W-2:0], ge};
      rem_q <= ge ? lwma_pkg::DVSR_W'(r2 - {1'b0, divisor_i}) : r2[lwma_pkg::DVSR_W-1:0];
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== sv/lwma_difficulty_retarget_top.sv =====
// ----------------------------------------------------------------------------
// lwma_difficulty_retarget_top
// lwma-3 difficulty retarget: one block word in, next required target out
// ----------------------------------------------------------------------------
// Each accepted word is one block. Until the window holds WINDOW+1 blocks the
// answer is the limit. With a full window the time for one word is set by the
// bit-serial 256-bit divider that runs once for every target in the window;
// the final product with the weighted solve-time sum is a shift-add pass.
// in_stall_o stays high while a word is worked on; a result waiting in the
// output register does not block the next word.
`include "lwma_difficulty_retarget_top_defines.svh"

module lwma_difficulty_retarget_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] block_time_i,
  input  logic [31:0] block_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_bits_o,
  output logic        window_full_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = lwma_pkg::IDX_W;

  lwma_pkg::state_e state_q, state_d;

  logic [lwma_pkg::T_W-1:0]    spacing_q;
  logic [31:0]                 limit_q;
  logic [31:0]                 time_mem [lwma_pkg::RING];
  logic [31:0]                 bits_mem [lwma_pkg::RING];
  logic [31:0]                 time_rd_q, bits_rd_q;
  logic [IW-1:0]               head_q, rd_idx_q;
  logic [lwma_pkg::SEEN_W-1:0] seen_q;
  logic [lwma_pkg::J_W-1:0]    j_q;
  logic                        first_q, full_q;
  logic [lwma_pkg::PREV_W-1:0] prev_q;
  logic [lwma_pkg::CAP_W-1:0]  cap_q, solve_q;
  logic [lwma_pkg::TACC_W-1:0] t_q;
  logic [lwma_pkg::DVSR_W-1:0] divisor_q;
  logic [lwma_pkg::NUM_W-1:0]  sum_q, val_q, lim_q;
  logic [lwma_pkg::SIZE_W-1:0] size_q;
  logic [lwma_pkg::MCNT_W-1:0] mcnt_q;
  logic                        out_valid_q, window_full_q;
  logic [31:0]                 next_bits_q;

  logic                        in_acc, cfg_wr, seen_full, div_start, out_load;
  logic [lwma_pkg::NUM_W-1:0]  quotient;
  lwma_pkg::div_stat_t         div_stat;
  logic [lwma_pkg::T_W-1:0]    t_eff;
  logic [lwma_pkg::T_W+lwma_pkg::DIVK_W-1:0] dvsr_prod;
  logic [lwma_pkg::PREV_W-1:0] ts_ext, cur, diff;
  logic [23:0]                 mant;
  logic [31:0]                 enc;
  logic [lwma_pkg::TACC_W-1:0] wt;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(lwma_pkg::RING - 1)) ? '0 : i + 1'b1;
  endfunction

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (lwma_pkg::reg_idx_e'(paddr[2]) == lwma_pkg::REG_LIMIT) ? limit_q
                                                                           : {16'h0, spacing_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= lwma_pkg::SPACING_RST;
      limit_q   <= lwma_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      case (lwma_pkg::reg_idx_e'(paddr[2]))
        lwma_pkg::REG_SPACING: spacing_q <= pwdata[lwma_pkg::T_W-1:0];
        lwma_pkg::REG_LIMIT:   limit_q   <= pwdata;
        default: ;
      endcase
    end
  end

  assign in_acc    = in_valid_i & ~in_stall_o;
  assign seen_full = seen_q == lwma_pkg::SEEN_W'(lwma_pkg::RING);
  assign t_eff     = (spacing_q == '0) ? lwma_pkg::T_W'(1) : spacing_q;
  assign dvsr_prod = t_eff * lwma_pkg::DIVK_W'(lwma_pkg::DIVK);
  assign ts_ext    = {1'b0, time_rd_q};
  assign cur       = (ts_ext > prev_q) ? ts_ext : prev_q + 1'b1;
  assign diff      = cur - prev_q;
  assign mant      = val_q[lwma_pkg::NUM_W-1 -: 24];
  assign wt        = lwma_pkg::TACC_W'(solve_q) * lwma_pkg::TACC_W'(j_q);
  assign enc       = mant[23] ? {8'({2'b00, size_q} + 1'b1), 8'h00, mant[23:8]}
                              : {8'(size_q), mant};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lwma_pkg::ST_IDLE:   if (in_valid_i) state_d = lwma_pkg::ST_START;
      lwma_pkg::ST_START:  state_d = full_q ? lwma_pkg::ST_FETCH : lwma_pkg::ST_NORM;
      lwma_pkg::ST_FETCH:  state_d = lwma_pkg::ST_ENTRY;
      lwma_pkg::ST_ENTRY:  state_d = first_q ? lwma_pkg::ST_FETCH : lwma_pkg::ST_DIV;
      lwma_pkg::ST_DIV:    if (div_stat.done) state_d = lwma_pkg::ST_ACC;
      lwma_pkg::ST_ACC:    state_d = (j_q == lwma_pkg::J_W'(lwma_pkg::WINDOW)) ?
                                     lwma_pkg::ST_MUL : lwma_pkg::ST_FETCH;
      lwma_pkg::ST_MUL:    if (mcnt_q == lwma_pkg::MCNT_W'(lwma_pkg::TACC_W - 1))
                             state_d = lwma_pkg::ST_CLAMP;
      lwma_pkg::ST_CLAMP:  state_d = lwma_pkg::ST_NORM;
      lwma_pkg::ST_NORM:   if (size_q == '0 || mant[23:16] != 8'h00)
                             state_d = lwma_pkg::ST_FINISH;
      lwma_pkg::ST_FINISH: if (out_load) state_d = lwma_pkg::ST_IDLE;
      default:             state_d = lwma_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = state_q != lwma_pkg::ST_IDLE;
    div_start  = (state_q == lwma_pkg::ST_ENTRY) && !first_q;
    out_load   = (state_q == lwma_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lwma_pkg::ST_IDLE;
      head_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        head_q <= idx_inc(head_q);
        if (!seen_full) seen_q <= seen_q + 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // ring memories
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      time_mem[head_q] <= block_time_i;
      bits_mem[head_q] <= block_bits_i;
    end
    time_rd_q <= time_mem[rd_idx_q];
    bits_rd_q <= bits_mem[rd_idx_q];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      next_bits_q   <= enc;
      window_full_q <= full_q;
    end
    case (state_q)
      lwma_pkg::ST_IDLE: begin
        full_q <= seen_full || (seen_q == lwma_pkg::SEEN_W'(lwma_pkg::RING - 1));
      end
      lwma_pkg::ST_START: begin
        lim_q     <= lwma_pkg::decode_compact(limit_q);
        val_q     <= lwma_pkg::decode_compact(limit_q);
        size_q    <= lwma_pkg::SIZE_W'(lwma_pkg::NBYTES);
        divisor_q <= dvsr_prod[lwma_pkg::DVSR_W-1:0];
        cap_q     <= lwma_pkg::CAP_W'(t_eff) * lwma_pkg::CAP_W'(6);
        rd_idx_q  <= head_q;
        first_q   <= 1'b1;
        t_q       <= '0;
        sum_q     <= '0;
        j_q       <= lwma_pkg::J_W'(1);
      end
      lwma_pkg::ST_ENTRY: begin
        if (first_q) begin
          prev_q   <= ts_ext;
          first_q  <= 1'b0;
          rd_idx_q <= idx_inc(rd_idx_q);
        end else begin
          prev_q  <= cur;
          solve_q <= (diff > lwma_pkg::PREV_W'(cap_q)) ? cap_q : diff[lwma_pkg::CAP_W-1:0];
        end
      end
      lwma_pkg::ST_ACC: begin
        sum_q    <= sum_q + quotient;
        t_q      <= t_q + wt;
        j_q      <= j_q + 1'b1;
        rd_idx_q <= idx_inc(rd_idx_q);
        val_q    <= '0;
        mcnt_q   <= '0;
      end
      lwma_pkg::ST_MUL: begin
        val_q  <= (val_q << 1) + (t_q[lwma_pkg::TACC_W-1] ? sum_q : '0);
        t_q    <= t_q << 1;
        mcnt_q <= mcnt_q + 1'b1;
      end
      lwma_pkg::ST_CLAMP: begin
        if (val_q > lim_q) val_q <= lim_q;
        size_q <= lwma_pkg::SIZE_W'(lwma_pkg::NBYTES);
      end
      lwma_pkg::ST_NORM: begin
        if (size_q != '0 && mant[23:16] == 8'h00) begin
          val_q  <= val_q << 8;
          size_q <= size_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  lwma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lwma_pkg::decode_compact(bits_rd_q)),
    .divisor_i  (divisor_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign out_valid_o   = out_valid_q;
  assign next_bits_o   = next_bits_q;
  assign window_full_o = window_full_q;

  `LWMA_ASSERT_IMP(a_full_word, out_valid_o && window_full_o, seen_full)
  `LWMA_ASSERT_NXT(a_div_to_acc, state_q == lwma_pkg::ST_DIV && div_stat.done, state_q == lwma_pkg::ST_ACC)
  `LWMA_ASSERT_IMP(a_div_owned, div_stat.busy, state_q == lwma_pkg::ST_DIV)
  `LWMA_ASSERT_NXT(a_finish_hold, state_q == lwma_pkg::ST_FINISH && out_valid_o && out_stall_i, state_q == lwma_pkg::ST_FINISH)

endmodule
